// ----- design/edaf_pkg.sv -----
// Shared types and constants for the EWMA deviation anomaly flag block.
// Used by the controller, the datapath and the top level; depends on nothing.
package edaf_pkg;

  localparam int unsigned LOSS_W   = 32;
  localparam int unsigned SMOOTH_W = 17;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W   = SMOOTH_W + LOSS_W;
  localparam int unsigned STATE_W  = 4;

  // Q1.16 one for the weight and Q16.16 one for the deviation sentinel.
  localparam logic [SMOOTH_W-1:0] WEIGHT_ONE = 17'd65536;
  localparam logic [LOSS_W-1:0]   DEV_ONE    = 32'd65536;
  localparam logic [PROD_W:0]     ROUND_HALF = 50'd32768;

  // Reset values of the registers.
  localparam logic [SMOOTH_W-1:0] SMOOTH_RST = 17'd6554;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd512;

  // Register indexes on the write port.
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_ONLY  = 2'd2;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_W_LOSS,
    MUL_WC_AVG,
    MUL_WC_DEV,
    MUL_W_DIFF,
    MUL_K_DEV
  } mul_sel_e;

  typedef struct packed {
    logic     loss_load;
    mul_sel_e mul_sel;
    logic     acc_load;
    logic     avg_upd;
    logic     diff_load;
    logic     dev_upd;
    logic     lvl_upd;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic avg_only;
  } dp_sts_t;

endpackage

// ----- design/edaf_ctrl.sv -----
// Sequencer for the anomaly flag block: steps one sample through the
// shared multiplier and owns the handshakes. Depends on edaf_pkg.
module edaf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  edaf_pkg::dp_sts_t sts_i,
  output edaf_pkg::dp_cmd_t cmd_o
);

  localparam logic [edaf_pkg::STATE_W-1:0] S_IDLE = 4'd0;
  localparam logic [edaf_pkg::STATE_W-1:0] S_MA   = 4'd1;
  localparam logic [edaf_pkg::STATE_W-1:0] S_MB   = 4'd2;
  localparam logic [edaf_pkg::STATE_W-1:0] S_AVG  = 4'd3;
  localparam logic [edaf_pkg::STATE_W-1:0] S_D1   = 4'd4;
  localparam logic [edaf_pkg::STATE_W-1:0] S_D2   = 4'd5;
  localparam logic [edaf_pkg::STATE_W-1:0] S_DEV  = 4'd6;
  localparam logic [edaf_pkg::STATE_W-1:0] S_KM   = 4'd7;
  localparam logic [edaf_pkg::STATE_W-1:0] S_EVT  = 4'd8;
  localparam logic [edaf_pkg::STATE_W-1:0] S_OUT  = 4'd9;

  logic [edaf_pkg::STATE_W-1:0] state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.mul_sel = edaf_pkg::MUL_W_LOSS;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.loss_load = 1'b1;
          state_d = S_MA;
        end
      end
      S_MA: begin
        cmd_o.mul_sel = edaf_pkg::MUL_W_LOSS;
        state_d = S_MB;
      end
      S_MB: begin
        cmd_o.mul_sel  = edaf_pkg::MUL_WC_AVG;
        cmd_o.acc_load = 1'b1;
        state_d = S_AVG;
      end
      S_AVG: begin
        cmd_o.avg_upd = 1'b1;
        state_d = sts_i.avg_only ? S_OUT : S_D1;
      end
      S_D1: begin
        cmd_o.mul_sel   = edaf_pkg::MUL_WC_DEV;
        cmd_o.diff_load = 1'b1;
        state_d = S_D2;
      end
      S_D2: begin
        cmd_o.mul_sel  = edaf_pkg::MUL_W_DIFF;
        cmd_o.acc_load = 1'b1;
        state_d = S_DEV;
      end
      S_DEV: begin
        cmd_o.dev_upd = 1'b1;
        state_d = S_KM;
      end
      S_KM: begin
        cmd_o.mul_sel = edaf_pkg::MUL_K_DEV;
        state_d = S_EVT;
      end
      S_EVT: begin
        cmd_o.lvl_upd = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/edaf_dp.sv -----
// Datapath for the anomaly flag block: registers, running state and one
// shared 17x32 multiplier with a rounding accumulator. Depends on edaf_pkg.
module edaf_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [edaf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [edaf_pkg::SMOOTH_W-1:0]      cfg_data_i,
  input  logic [edaf_pkg::LOSS_W-1:0]        loss_i,
  output logic                               anomaly_o,
  input  edaf_pkg::dp_cmd_t                  cmd_i,
  output edaf_pkg::dp_sts_t                  sts_o
);

  logic [edaf_pkg::SMOOTH_W-1:0] smooth_q;
  logic [edaf_pkg::GAIN_W-1:0]   gain_q;
  logic                          avg_only_q;

  logic [edaf_pkg::LOSS_W-1:0]   loss_q, diff_q;
  logic [edaf_pkg::LOSS_W-1:0]   avg_q, dev_q, event_q, normal_q;
  logic [edaf_pkg::PROD_W-1:0]   prod_q, acc_q;
  logic                          anomaly_q;

  logic [edaf_pkg::SMOOTH_W-1:0] weight, weight_c, mul_a;
  logic [edaf_pkg::LOSS_W-1:0]   mul_b;
  logic [edaf_pkg::PROD_W-1:0]   prod_d;
  logic [edaf_pkg::PROD_W:0]     blend_sum;
  logic [edaf_pkg::LOSS_W-1:0]   blend_res, diff_d;
  logic [edaf_pkg::PROD_W-1:0]   lhs, rhs;
  logic [edaf_pkg::LOSS_W:0]     lvl_sum, loss_x2;
  logic                          flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q   <= edaf_pkg::SMOOTH_RST;
      gain_q     <= edaf_pkg::GAIN_RST;
      avg_only_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == edaf_pkg::CFG_SMOOTHING) begin
        smooth_q <= cfg_data_i;
      end
      if (cfg_index_i == edaf_pkg::CFG_GAIN) begin
        gain_q <= cfg_data_i[edaf_pkg::GAIN_W-1:0];
      end
      if (cfg_index_i == edaf_pkg::CFG_AVG_ONLY) begin
        avg_only_q <= cfg_data_i[0];
      end
    end
  end

  assign sts_o.avg_only = avg_only_q;

  // Weights above one saturate to one.
  assign weight   = (smooth_q > edaf_pkg::WEIGHT_ONE) ? edaf_pkg::WEIGHT_ONE : smooth_q;
  assign weight_c = edaf_pkg::WEIGHT_ONE - weight;

  always_comb begin
    unique case (cmd_i.mul_sel)
      edaf_pkg::MUL_W_LOSS: begin
        mul_a = weight;
        mul_b = loss_q;
      end
      edaf_pkg::MUL_WC_AVG: begin
        mul_a = weight_c;
        mul_b = avg_q;
      end
      edaf_pkg::MUL_WC_DEV: begin
        mul_a = weight_c;
        mul_b = dev_q;
      end
      edaf_pkg::MUL_W_DIFF: begin
        mul_a = weight;
        mul_b = diff_q;
      end
      edaf_pkg::MUL_K_DEV: begin
        mul_a = edaf_pkg::SMOOTH_W'(gain_q);
        mul_b = dev_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = edaf_pkg::PROD_W'(mul_a) * edaf_pkg::PROD_W'(mul_b);

  // The blend never exceeds the larger input, so bits above 47 stay zero.
  assign blend_sum = (edaf_pkg::PROD_W + 1)'(acc_q) + (edaf_pkg::PROD_W + 1)'(prod_q)
                     + edaf_pkg::ROUND_HALF;
  assign blend_res = blend_sum[edaf_pkg::LOSS_W+15:16];

  assign diff_d = (loss_q >= avg_q) ? (loss_q - avg_q) : (avg_q - loss_q);

  // Event test in Q25.24: avg + k*dev < loss.
  assign lhs = edaf_pkg::PROD_W'({avg_q, 8'h00}) + prod_q;
  assign rhs = edaf_pkg::PROD_W'({loss_q, 8'h00});

  assign lvl_sum = (edaf_pkg::LOSS_W + 1)'(event_q) + (edaf_pkg::LOSS_W + 1)'(normal_q);
  assign loss_x2 = {loss_q, 1'b0};
  assign flag_d  = avg_only_q ? (loss_x2 > {1'b0, avg_q}) : (loss_x2 > lvl_sum);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.loss_load) begin
      loss_q <= loss_i;
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q;
    end
    if (cmd_i.diff_load) begin
      diff_q <= diff_d;
    end
    if (cmd_i.out_load) begin
      anomaly_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q    <= '0;
      dev_q    <= edaf_pkg::DEV_ONE;
      event_q  <= '0;
      normal_q <= '0;
    end else begin
      if (cmd_i.avg_upd) begin
        avg_q <= (avg_q != '0) ? blend_res : loss_q;
      end
      if (cmd_i.dev_upd) begin
        dev_q <= (dev_q != edaf_pkg::DEV_ONE) ? blend_res : loss_q;
      end
      if (cmd_i.lvl_upd) begin
        if (lhs < rhs) begin
          event_q <= loss_q;
        end else begin
          normal_q <= loss_q;
        end
      end
    end
  end

  assign anomaly_o = anomaly_q;

endmodule

// ----- design/ema_deviation_anomaly_flag_core.sv -----
// Top level of the EWMA deviation anomaly flag block.
// Instantiates edaf_ctrl and edaf_dp; types and constants from edaf_pkg.

// One loss sample (unsigned Q16.16) in, one anomaly bit out. One 17x32
// multiplier forms the five products of the average, deviation and event
// tests one after another, so a sample is through its steps before the next
// is taken; average-only mode skips the deviation and event steps.
// The result sits in an output register, so the next sample is taken while a
// flag still waits. A sample that finishes while the previous flag is still
// waiting holds in its last step until that flag is taken. Registers (0
// smoothing, 1 deviation gain, 2 average-only mode) are always writable and
// must be changed only while the block is idle.
module ema_deviation_anomaly_flag_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [edaf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [edaf_pkg::SMOOTH_W-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [edaf_pkg::LOSS_W-1:0]        loss_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               anomaly_o
);

  edaf_pkg::dp_cmd_t cmd;
  edaf_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  edaf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  edaf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .loss_i      (loss_i),
    .anomaly_o   (anomaly_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- design/edaf_checker.sv -----
// Port-level checks for the anomaly flag block, bound to the top level.
// Sees only the ports of ema_deviation_anomaly_flag_core.
module edaf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic anomaly_o
);

  // A waiting flag holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(anomaly_o))
    else $error("result changed or dropped while stalled");

  // After a request is taken the block stays busy and keeps its input closed.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o
      ##1 !in_ready_o)
    else $error("input reopened too early");

  // A new result only appears while a sample is being worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared with no sample in flight");

endmodule

bind ema_deviation_anomaly_flag_core edaf_checker u_edaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .anomaly_o   (anomaly_o)
);
